### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the animation timeline sequencer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent this cycle implies consequent in the next cycle
`define ATL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("atl: next-cycle property failed");

// Antecedent implies consequent in the same cycle
`define ATL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("atl: same-cycle property failed");

`endif

### hw/rtl/atl_pkg.sv
// Shared types and constants of the animation timeline sequencer.
// Depends on nothing; used by the interfaces and every module.
package atl_pkg;

    // Default widths
    localparam int TIME_BITS_DEF = 40;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int DUR_W  = 32;
    localparam int ITER_W = 31;
    localparam int SEEK_W = 32;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    localparam logic [IDX_W-1:0] REG_DURATION = 3'd0;
    localparam logic [IDX_W-1:0] REG_DELAY    = 3'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FOREVER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_REVERSE  = 3'd4;

    localparam logic [DUR_W-1:0]  DURATION_RST = 32'd300;
    localparam logic [ITER_W-1:0] ITER_MAX     = {ITER_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_FRAME   = 3'd0,
        OP_START   = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_SEEK    = 3'd4,
        OP_END     = 3'd5,
        OP_CANCEL  = 3'd6,
        OP_REVERSE = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_DELAYED = 2'd2,
        PH_ACTIVE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PS_STOPPED = 2'd0,
        PS_RUNNING = 2'd1,
        PS_SEEKED  = 2'd2
    } t_play;

    typedef struct packed {
        logic [DUR_W-1:0]  duration;
        logic [DUR_W-1:0]  start_delay;
        logic [ITER_W-1:0] repeat_count;
        logic              repeat_forever;
        logic              repeat_reverse;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic prep;
        logic dchk;
        logic frame;
        logic load;
        logic div_step;
        logic apply;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic to_dchk;
        logic to_frame;
        logic dchk_go;
        logic frame_go;
        logic div_skip;
    } t_sts;

endpackage

### hw/rtl/atl_if.sv
// Valid/ready channel interfaces for the event and result streams.
// Depends on atl_pkg for field widths.
interface atl_in_if #(
    parameter int TIME_BITS = atl_pkg::TIME_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [atl_pkg::OP_W-1:0]    op;
    logic [TIME_BITS-1:0]        event_time;
    logic                        start_backwards;
    logic [atl_pkg::SEEK_W-1:0]  seek_position;

    modport source (output valid, op, event_time, start_backwards, seek_position,
                    input ready);
    modport sink   (input valid, op, event_time, start_backwards, seek_position,
                    output ready);
endinterface

interface atl_out_if #(
    parameter int FRACTION_BITS = atl_pkg::FRAC_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic                        value_valid;
    logic [FRACTION_BITS:0]      fraction;
    logic                        done_res;
    logic                        is_running;
    logic [atl_pkg::ITER_W-1:0]  iteration;
    logic                        playing_backwards;

    modport source (output valid, value_valid, fraction, done_res, is_running, iteration,
                    playing_backwards, input ready);
    modport sink   (input valid, value_valid, fraction, done_res, is_running, iteration,
                    playing_backwards, output ready);
endinterface

### hw/rtl/animation_timeline_sequencer.sv
// Animation timeline sequencer: timestamped events in, one timeline result out.
//
// i_in carries one event per transfer (op, event_time, start_backwards,
// seek_position); o_out returns exactly one result per event. Registers are
// written over the APB port (duration, start delay, repeat count, repeat
// forever, repeat reverse at byte offsets 0, 4, 8, 12, 16); the user must
// write them only while idle; the block does not enforce it. Events are taken
// one at a time. An event that computes no fraction goes from prepare to
// emit. A frame, seek or immediate start that produces a fraction runs the
// bit-serial divider for a TIME_BITS+1+FRACTION_BITS bit quotient (57 at
// the defaults), through prepare, delay check (frames in a start delay),
// frame, load, divide (unless duration is zero), apply and emit. The divider
// loop sets the rate. The finished result sits in an output register, so
// the next event is taken while it waits; a further result is held back
// until the receiver takes the pending one. Reset is synchronous and returns
// the timeline to idle and the registers to their defaults; no clearing pass.
//
// Depends on atl_pkg, atl_if, atl_cfg, atl_ctrl and atl_dpath.
module animation_timeline_sequencer #(
    parameter int TIME_BITS     = atl_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = atl_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    atl_in_if.sink                       i_in,
    atl_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [atl_pkg::APB_AW-1:0]   paddr,
    input  logic [atl_pkg::APB_DW-1:0]   pwdata,
    output logic [atl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import atl_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    atl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    atl_ctrl #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    atl_dpath #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg               (w_cfg),
        .i_op                (i_in.op),
        .i_event_time        (i_in.event_time),
        .i_start_backwards   (i_in.start_backwards),
        .i_seek_position     (i_in.seek_position),
        .o_value_valid       (o_out.value_valid),
        .o_fraction          (o_out.fraction),
        .o_done_res          (o_out.done_res),
        .o_is_running        (o_out.is_running),
        .o_iteration         (o_out.iteration),
        .o_playing_backwards (o_out.playing_backwards)
    );

endmodule

### hw/rtl/atl_cfg.sv
// APB register bank: duration, start delay and repeat settings.
// Depends on atl_pkg.
module atl_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [atl_pkg::APB_AW-1:0]   paddr,
    input  logic [atl_pkg::APB_DW-1:0]   pwdata,
    output logic [atl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output atl_pkg::t_cfg                o_cfg
);
    import atl_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duration       <= DURATION_RST;
            r_cfg.start_delay    <= '0;
            r_cfg.repeat_count   <= '0;
            r_cfg.repeat_forever <= 1'b0;
            r_cfg.repeat_reverse <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_DURATION: r_cfg.duration       <= pwdata[DUR_W-1:0];
                REG_DELAY:    r_cfg.start_delay    <= pwdata[DUR_W-1:0];
                REG_REPEAT:   r_cfg.repeat_count   <= pwdata[ITER_W-1:0];
                REG_FOREVER:  r_cfg.repeat_forever <= pwdata[0];
                REG_REVERSE:  r_cfg.repeat_reverse <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_DURATION: prdata = APB_DW'(r_cfg.duration);
            REG_DELAY:    prdata = APB_DW'(r_cfg.start_delay);
            REG_REPEAT:   prdata = APB_DW'(r_cfg.repeat_count);
            REG_FOREVER:  prdata = APB_DW'(r_cfg.repeat_forever);
            REG_REVERSE:  prdata = APB_DW'(r_cfg.repeat_reverse);
            default:      prdata = '0;
        endcase
    end

endmodule

### hw/rtl/atl_ctrl.sv
// Sequencing state machine: accepts an event, steps the datapath, emits one result.
// Depends on atl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atl_ctrl #(
    parameter int TIME_BITS     = atl_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = atl_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  atl_pkg::t_sts i_sts,
    output atl_pkg::t_cmd o_cmd
);
    import atl_pkg::*;

    localparam int DIV_W = TIME_BITS + 1 + FRACTION_BITS;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DCHK, S_FRAME, S_LOAD, S_DIV, S_APPLY, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.to_dchk)       n_state = S_DCHK;
                else if (i_sts.to_frame) n_state = S_FRAME;
                else                     n_state = S_EMIT;
            end
            S_DCHK: begin
                o_cmd.dchk = 1'b1;
                n_state    = i_sts.dchk_go ? S_FRAME : S_EMIT;
            end
            S_FRAME: begin
                o_cmd.frame = 1'b1;
                n_state     = i_sts.frame_go ? S_LOAD : S_EMIT;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.div_skip ? S_APPLY : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // hold the result until the output register is free
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `ATL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ATL_ASSERT_NEXT(a_emit_sets_valid, i_clk, i_rst_n, o_cmd.emit, o_out_valid)
    `ATL_ASSERT_NEXT(a_div_ends_apply, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == CNT_LAST), r_state == S_APPLY)
    `ATL_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.emit, !o_out_valid || i_out_ready)

endmodule

### hw/rtl/atl_dpath.sv
// Timeline state, event decode, serial fraction divider and result register.
// Depends on atl_pkg; driven by commands from atl_ctrl.
module atl_dpath #(
    parameter int TIME_BITS     = atl_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = atl_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  atl_pkg::t_cmd                i_cmd,
    output atl_pkg::t_sts                o_sts,
    input  atl_pkg::t_cfg                i_cfg,
    input  logic [atl_pkg::OP_W-1:0]     i_op,
    input  logic [TIME_BITS-1:0]         i_event_time,
    input  logic                         i_start_backwards,
    input  logic [atl_pkg::SEEK_W-1:0]   i_seek_position,
    output logic                         o_value_valid,
    output logic [FRACTION_BITS:0]       o_fraction,
    output logic                         o_done_res,
    output logic                         o_is_running,
    output logic [atl_pkg::ITER_W-1:0]   o_iteration,
    output logic                         o_playing_backwards
);
    import atl_pkg::*;

    localparam int TW    = TIME_BITS;
    localparam int STW   = TIME_BITS + 1;
    localparam int FW    = FRACTION_BITS;
    localparam int FOW   = FRACTION_BITS + 1;
    localparam int DIV_W = STW + FW;
    localparam int CW    = ((STW > DUR_W) ? STW : DUR_W) + 1;
    localparam int QCW   = (STW > ITER_W) ? STW : ITER_W;
    localparam logic [FOW-1:0] FRAC_ONE = {1'b1, {FW{1'b0}}};

    // Latched event
    t_op                r_op;
    logic [TW-1:0]      r_t;
    logic               r_back;
    logic [SEEK_W-1:0]  r_p;

    // Timeline state
    t_phase             r_phase, n_phase;
    t_play              r_ps, n_ps;
    logic [STW-1:0]     r_start, n_start;
    logic               r_seek_vld, n_seek_vld;
    logic [SEEK_W-1:0]  r_seek, n_seek;
    logic [TW-1:0]      r_dst, n_dst;
    logic               r_dstarted, n_dstarted;
    logic               r_pause_none, n_pause_none;
    logic [TW-1:0]      r_pause, n_pause;
    logic               r_paused, n_paused;
    logic               r_resumed, n_resumed;
    logic               r_bw, n_bw;
    logic [ITER_W-1:0]  r_iter, n_iter;
    logic               r_started, n_started;
    logic               r_running, n_running;
    logic               r_starting, n_starting;

    // Per-event result
    logic               r_anim_vld, n_anim_vld;
    logic [FOW-1:0]     r_anim_frac, n_anim_frac;
    logic               r_ended, n_ended;

    // Divider
    logic [DUR_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_quo, n_quo;

    // Result register
    logic               r_o_vv;
    logic [FOW-1:0]     r_o_frac;
    logic               r_o_done;
    logic               r_o_run;
    logic [ITER_W-1:0]  r_o_iter;
    logic               r_o_bw;

    logic               w_dur0;
    logic               w_delay0;
    logic               w_pause_pos;

    assign w_dur0      = (i_cfg.duration == '0);
    assign w_delay0    = (i_cfg.start_delay == '0);
    assign w_pause_pos = !r_pause_none && (r_pause != '0);

    always_comb begin
        t_phase           ph;
        logic [TW-1:0]    ds;
        logic [STW-1:0]   base;
        logic [STW-1:0]   du;
        logic [STW-1:0]   el;
        logic [STW-1:0]   q;
        logic [ITER_W-1:0] room;
        logic [FOW-1:0]   fr;
        logic [DUR_W:0]   cand;
        logic             bw;
        logic             done;
        logic             st_go;
        logic             st_back;
        logic             en_go;
        logic             en_bw;
        logic             es_go;

        ph      = r_phase;
        ds      = r_dst;
        base    = r_start;
        du      = '0;
        el      = '0;
        q       = '0;
        room    = '0;
        fr      = '0;
        cand    = '0;
        bw      = r_bw;
        done    = 1'b0;
        st_go   = 1'b0;
        st_back = 1'b0;
        en_go   = 1'b0;
        en_bw   = 1'b0;
        es_go   = 1'b0;

        n_phase      = r_phase;
        n_ps         = r_ps;
        n_start      = r_start;
        n_seek_vld   = r_seek_vld;
        n_seek       = r_seek;
        n_dst        = r_dst;
        n_dstarted   = r_dstarted;
        n_pause_none = r_pause_none;
        n_pause      = r_pause;
        n_paused     = r_paused;
        n_resumed    = r_resumed;
        n_bw         = r_bw;
        n_iter       = r_iter;
        n_started    = r_started;
        n_running    = r_running;
        n_starting   = r_starting;
        n_anim_vld   = r_anim_vld;
        n_anim_frac  = r_anim_frac;
        n_ended      = r_ended;
        n_rem        = r_rem;
        n_quo        = r_quo;
        o_sts        = '0;

        // Decode the event and apply its immediate effects
        if (i_cmd.prep) begin
            n_anim_vld  = 1'b0;
            n_anim_frac = '0;
            n_ended     = 1'b0;
            n_starting  = 1'b0;
            case (r_op)
                OP_FRAME: begin
                    if (ph == PH_PENDING) ph = w_delay0 ? PH_ACTIVE : PH_DELAYED;
                    n_phase = ph;
                    if (ph == PH_DELAYED) begin
                        if (!r_dstarted) ds = r_t;
                        n_dstarted = 1'b1;
                        if (r_paused) begin
                            if (r_pause_none) begin
                                n_pause      = r_t;
                                n_pause_none = 1'b0;
                            end
                        end else begin
                            if (r_resumed) begin
                                n_resumed = 1'b0;
                                if (w_pause_pos) ds = ds + r_t - r_pause;
                            end
                            o_sts.to_dchk = 1'b1;
                        end
                        n_dst = ds;
                    end else if (ph == PH_ACTIVE) begin
                        o_sts.to_frame = 1'b1;
                    end
                end
                OP_START: begin
                    st_go   = 1'b1;
                    st_back = r_back;
                end
                OP_PAUSE: begin
                    if (r_started && !r_paused) begin
                        n_paused     = 1'b1;
                        n_pause_none = 1'b1;
                        n_resumed    = 1'b0;
                    end
                end
                OP_RESUME: begin
                    if (r_paused) begin
                        n_resumed = 1'b1;
                        n_paused  = 1'b0;
                    end
                end
                OP_SEEK: begin
                    if (r_ps != PS_RUNNING) begin
                        n_seek_vld = 1'b1;
                        n_seek     = r_p;
                        n_ps       = PS_SEEKED;
                    end
                    n_start        = STW'(r_t) - STW'(r_p);
                    o_sts.to_frame = 1'b1;
                end
                OP_END: begin
                    en_go = 1'b1;
                    en_bw = r_bw;
                end
                OP_CANCEL: begin
                    if (r_ps != PS_STOPPED || r_phase == PH_PENDING || r_phase == PH_DELAYED)
                        es_go = 1'b1;
                end
                OP_REVERSE: begin
                    n_bw = !r_bw;
                    if (r_ps == PS_RUNNING) begin
                        // mirror the played time about the end
                        n_start = {r_t, 1'b0} - STW'(i_cfg.duration) - r_start;
                    end else if (r_started) begin
                        en_go = 1'b1;
                        en_bw = !r_bw;
                    end else begin
                        st_go   = 1'b1;
                        st_back = 1'b1;
                    end
                end
                default: ;
            endcase

            // Arm the timeline; with no delay run the first step now
            if (st_go) begin
                n_bw       = st_back;
                n_iter     = '0;
                n_ps       = PS_STOPPED;
                n_started  = 1'b1;
                n_dstarted = 1'b0;
                n_paused   = 1'b0;
                n_phase    = PH_PENDING;
                if (w_delay0) begin
                    n_seek_vld     = 1'b1;
                    n_seek         = '0;
                    n_ps           = PS_SEEKED;
                    n_start        = STW'(r_t);
                    n_starting     = 1'b1;
                    o_sts.to_frame = 1'b1;
                end
            end

            // Jump to the end
            if (en_go) begin
                if (r_phase != PH_ACTIVE && r_phase != PH_PENDING) n_dstarted = 1'b0;
                n_anim_vld  = 1'b1;
                n_anim_frac = en_bw ? '0 : FRAC_ONE;
                es_go       = 1'b1;
            end

            if (es_go) begin
                n_phase   = PH_IDLE;
                n_ps      = PS_STOPPED;
                n_paused  = 1'b0;
                n_running = 1'b0;
                n_started = 1'b0;
                n_bw      = 1'b0;
                n_ended   = 1'b1;
            end
        end

        // Check whether the start delay has run out
        if (i_cmd.dchk) begin
            du = {1'b0, r_t} - {1'b0, r_dst};
            if (!du[TW] && (CW'(du) > CW'(i_cfg.start_delay))) begin
                o_sts.dchk_go = 1'b1;
                n_start       = STW'(r_dst) + STW'(i_cfg.start_delay);
                n_ps          = PS_RUNNING;
                n_phase       = PH_ACTIVE;
                n_running     = 1'b1;
            end
        end

        // Frame step: fix the start time, account for pause and resume
        if (i_cmd.frame) begin
            if (r_ps == PS_STOPPED) begin
                n_ps       = PS_RUNNING;
                base       = r_seek_vld ? (STW'(r_t) - STW'(r_seek)) : STW'(r_t);
                n_seek_vld = 1'b0;
            end
            if (r_paused) begin
                if (r_pause_none) begin
                    n_pause      = r_t;
                    n_pause_none = 1'b0;
                end
            end else begin
                o_sts.frame_go = 1'b1;
                if (r_resumed) begin
                    n_resumed = 1'b0;
                    if (w_pause_pos) base = base + STW'(r_t) - STW'(r_pause);
                end
            end
            n_start = base;
        end

        // Elapsed time into the divider, never taken before the start
        if (i_cmd.load) begin
            if ($signed(r_start) > $signed({1'b0, r_t})) el = '0;
            else                                         el = {1'b0, r_t} - r_start;
            n_quo          = {el, {FW{1'b0}}};
            n_rem          = '0;
            o_sts.div_skip = w_dur0;
        end

        // One restoring division step a cycle
        if (i_cmd.div_step) begin
            cand = {r_rem, r_quo[DIV_W-1]};
            if (cand >= {1'b0, i_cfg.duration}) begin
                n_rem = DUR_W'(cand - {1'b0, i_cfg.duration});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = cand[DUR_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
        end

        // Repeat or finish, then apply the direction
        if (i_cmd.apply) begin
            q  = w_dur0 ? STW'(1) : r_quo[DIV_W-1:FW];
            fr = w_dur0 ? '0 : {1'b0, r_quo[FW-1:0]};
            if (q != '0) begin
                if ((r_iter < i_cfg.repeat_count) || i_cfg.repeat_forever) begin
                    if (i_cfg.repeat_reverse) bw = !bw;
                    room = ITER_MAX - r_iter;
                    if (QCW'(q) >= QCW'(room)) n_iter = ITER_MAX;
                    else                       n_iter = r_iter + ITER_W'(q);
                    n_start = r_start + STW'(i_cfg.duration);
                end else begin
                    done = 1'b1;
                    fr   = FRAC_ONE;
                end
            end
            if (bw) fr = FRAC_ONE - fr;
            n_bw        = bw;
            n_anim_vld  = 1'b1;
            n_anim_frac = fr;
            if (r_starting) begin
                n_ps      = PS_STOPPED;
                n_running = 1'b1;
            end
            if (done && r_op == OP_FRAME) begin
                n_phase   = PH_IDLE;
                n_ps      = PS_STOPPED;
                n_paused  = 1'b0;
                n_running = 1'b0;
                n_started = 1'b0;
                n_bw      = 1'b0;
                n_ended   = 1'b1;
            end
        end
    end

    // Capture the accepted event
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= t_op'(i_op);
            r_t    <= i_event_time;
            r_back <= i_start_backwards;
            r_p    <= i_seek_position;
        end
    end

    // Timeline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_ps         <= PS_STOPPED;
            r_start      <= '0;
            r_seek_vld   <= 1'b0;
            r_seek       <= '0;
            r_dst        <= '0;
            r_dstarted   <= 1'b0;
            r_pause_none <= 1'b0;
            r_pause      <= '0;
            r_paused     <= 1'b0;
            r_resumed    <= 1'b0;
            r_bw         <= 1'b0;
            r_iter       <= '0;
            r_started    <= 1'b0;
            r_running    <= 1'b0;
            r_starting   <= 1'b0;
            r_anim_vld   <= 1'b0;
            r_anim_frac  <= '0;
            r_ended      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_ps         <= n_ps;
            r_start      <= n_start;
            r_seek_vld   <= n_seek_vld;
            r_seek       <= n_seek;
            r_dst        <= n_dst;
            r_dstarted   <= n_dstarted;
            r_pause_none <= n_pause_none;
            r_pause      <= n_pause;
            r_paused     <= n_paused;
            r_resumed    <= n_resumed;
            r_bw         <= n_bw;
            r_iter       <= n_iter;
            r_started    <= n_started;
            r_running    <= n_running;
            r_starting   <= n_starting;
            r_anim_vld   <= n_anim_vld;
            r_anim_frac  <= n_anim_frac;
            r_ended      <= n_ended;
        end
    end

    // Divider registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // Result register, loaded when the controller hands a transfer out
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_vv   <= r_anim_vld;
            r_o_frac <= r_anim_vld ? r_anim_frac : '0;
            r_o_done <= r_ended;
            r_o_run  <= (r_ps == PS_RUNNING) || r_running;
            r_o_iter <= r_iter;
            r_o_bw   <= r_bw;
        end
    end

    assign o_value_valid       = r_o_vv;
    assign o_fraction          = r_o_frac;
    assign o_done_res          = r_o_done;
    assign o_is_running        = r_o_run;
    assign o_iteration         = r_o_iter;
    assign o_playing_backwards = r_o_bw;

endmodule

### sim/animation_timeline_sequencer_tb.sv
// Self-checking testbench for the animation timeline sequencer.
// Depends on atl_pkg, atl_if and the RTL of animation_timeline_sequencer.
`timescale 1ns / 1ps

module animation_timeline_sequencer_tb;
    import atl_pkg::*;

    localparam logic [63:0] ST_MASK  = (64'd1 << 41) - 1;
    localparam logic [63:0] T_MASK   = (64'd1 << 40) - 1;
    localparam logic [63:0] ONE_FR   = 64'd1 << 16;
    localparam logic [63:0] ITER_TOP = 64'h7FFF_FFFF;
    localparam int          LIMIT    = 2000000;

    typedef struct {
        t_op         op;
        logic [39:0] t;
        bit          back;
        logic [31:0] pos;
        bit          drain;
    } event_t;

    typedef struct packed {
        bit          value_valid;
        logic [16:0] fraction;
        bit          done_res;
        bit          is_running;
        logic [30:0] iteration;
        bit          backwards;
    } result_t;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    atl_in_if  ev_if ();
    atl_out_if res_if ();

    animation_timeline_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    event_t  pending_events[$];
    result_t expected_results[$];
    int      n_fail    = 0;
    int      n_sent    = 0;
    int      n_checked = 0;
    int      cycles    = 0;
    logic [39:0] now_ms;

    // Timeline model state and register copy
    logic [63:0] c_dur, c_dly, c_rep;
    bit          c_fwd, c_rev;
    t_phase      tl_phase;
    t_play       tl_play;
    logic [63:0] tl_start, tl_dstart, tl_iter;
    longint      tl_seek, tl_pause;
    bit          tl_dly_on, tl_paused, tl_resumed, tl_bwd, tl_started, tl_runf;
    bit          anim_v, ended;
    logic [63:0] anim_f;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint sx41(logic [63:0] v);
        return longint'({{23{v[40]}}, v[40:0]});
    endfunction

    function automatic void timeline_reset();
        tl_phase = PH_IDLE;
        tl_play = PS_STOPPED;
        tl_start = 0;
        tl_seek = -1;
        tl_dstart = 0;
        tl_pause = 0;
        {tl_dly_on, tl_paused, tl_resumed, tl_bwd, tl_started, tl_runf} = '0;
        tl_iter = 0;
    endfunction

    function automatic bit timeline_tick(logic [63:0] cur);
        logic [63:0] el, q, r, fr;
        bit done;
        done = 0;
        if (tl_play != PS_RUNNING && tl_play != PS_SEEKED) return 0;
        el = cur - 64'(sx41(tl_start));
        if (c_dur == 0) begin
            q = 1;
            r = 0;
        end else begin
            q = el / c_dur;
            r = el % c_dur;
        end
        fr = (c_dur != 0) ? ((r << 16) / c_dur) : 64'd0;
        if (q >= 1) begin
            if (tl_iter < c_rep || c_fwd) begin
                if (c_rev) tl_bwd = !tl_bwd;
                tl_iter = (q >= ITER_TOP - tl_iter) ? ITER_TOP : tl_iter + q;
                tl_start = (tl_start + c_dur) & ST_MASK;
            end else begin
                done = 1;
                fr = ONE_FR;
            end
        end
        if (tl_bwd) fr = ONE_FR - fr;
        anim_v = 1;
        anim_f = fr;
        return done;
    endfunction

    function automatic bit run_frame(logic [63:0] ft);
        longint ss;
        if (tl_play == PS_STOPPED) begin
            tl_play = PS_RUNNING;
            if (tl_seek < 0) begin
                tl_start = ft & ST_MASK;
            end else begin
                tl_start = (ft - 64'(tl_seek)) & ST_MASK;
                tl_seek = -1;
            end
        end
        if (tl_paused) begin
            if (tl_pause < 0) tl_pause = longint'(ft);
            return 0;
        end else if (tl_resumed) begin
            tl_resumed = 0;
            if (tl_pause > 0) tl_start = (tl_start + ft - 64'(tl_pause)) & ST_MASK;
        end
        ss = sx41(tl_start);
        return timeline_tick(ss > longint'(ft) ? 64'(ss) : ft);
    endfunction

    function automatic bit delay_tick(logic [63:0] ct);
        longint delta;
        if (!tl_dly_on) begin
            tl_dly_on = 1;
            tl_dstart = ct;
        end
        if (tl_paused) begin
            if (tl_pause < 0) tl_pause = longint'(ct);
            return 0;
        end else if (tl_resumed) begin
            tl_resumed = 0;
            if (tl_pause > 0) tl_dstart = (tl_dstart + ct - 64'(tl_pause)) & T_MASK;
        end
        delta = sx41((ct - tl_dstart) & ST_MASK);
        if (delta > longint'(c_dly)) begin
            tl_start = (ct - 64'(delta) + c_dly) & ST_MASK;
            tl_play = PS_RUNNING;
            return 1;
        end
        return 0;
    endfunction

    function automatic void end_timeline();
        tl_phase = PH_IDLE;
        tl_play = PS_STOPPED;
        {tl_paused, tl_runf, tl_started, tl_bwd} = '0;
        ended = 1;
    endfunction

    function automatic void seek_timeline(logic [63:0] ct, logic [63:0] p);
        if (tl_play != PS_RUNNING) begin
            tl_seek = longint'(p);
            tl_play = PS_SEEKED;
        end
        tl_start = (ct - p) & ST_MASK;
        void'(run_frame(ct));
    endfunction

    function automatic void arm_timeline(logic [63:0] ct, bit back);
        tl_bwd = back;
        tl_iter = 0;
        tl_play = PS_STOPPED;
        tl_started = 1;
        tl_dly_on = 0;
        tl_paused = 0;
        tl_phase = PH_PENDING;
        if (c_dly == 0) begin
            seek_timeline(ct, 0);
            tl_play = PS_STOPPED;
            tl_runf = 1;
        end
    endfunction

    function automatic void finish_timeline();
        if (tl_phase != PH_ACTIVE && tl_phase != PH_PENDING) begin
            tl_dly_on = 0;
            tl_phase = PH_ACTIVE;
            tl_started = 1;
        end
        anim_v = 1;
        anim_f = tl_bwd ? 64'd0 : ONE_FR;
        end_timeline();
    endfunction

    // Advance the timeline by one event and return what the block must report
    function automatic result_t predict_timeline(event_t e);
        result_t res;
        logic [63:0] t, played;
        t = 64'(e.t);
        anim_v = 0;
        anim_f = 0;
        ended = 0;
        case (e.op)
            OP_FRAME: begin
                if (tl_phase == PH_PENDING) tl_phase = (c_dly == 0) ? PH_ACTIVE : PH_DELAYED;
                if (tl_phase == PH_DELAYED && delay_tick(t)) begin
                    tl_phase = PH_ACTIVE;
                    tl_runf = 1;
                end
                if (tl_phase == PH_ACTIVE && run_frame(t)) end_timeline();
            end
            OP_START: arm_timeline(t, e.back);
            OP_PAUSE: begin
                if (tl_started && !tl_paused) begin
                    tl_paused = 1;
                    tl_pause = -1;
                    tl_resumed = 0;
                end
            end
            OP_RESUME: begin
                if (tl_paused) begin
                    tl_resumed = 1;
                    tl_paused = 0;
                end
            end
            OP_SEEK: seek_timeline(t, 64'(e.pos));
            OP_END: finish_timeline();
            OP_CANCEL: begin
                if (tl_play != PS_STOPPED || tl_phase == PH_PENDING || tl_phase == PH_DELAYED)
                    end_timeline();
            end
            default: begin
                tl_bwd = !tl_bwd;
                if (tl_play == PS_RUNNING) begin
                    played = t - 64'(sx41(tl_start));
                    tl_start = (t - (c_dur - played)) & ST_MASK;
                end else if (tl_started) begin
                    finish_timeline();
                end else begin
                    arm_timeline(t, 1'b1);
                end
            end
        endcase
        res.value_valid = anim_v;
        res.fraction = anim_v ? anim_f[16:0] : 17'd0;
        res.done_res = ended;
        res.is_running = (tl_play == PS_RUNNING) || tl_runf;
        res.iteration = tl_iter[30:0];
        res.backwards = tl_bwd;
        return res;
    endfunction

    // Event driver: offer queued events, predict on each transfer
    int ev_gap;
    always @(posedge i_clk) begin
        event_t e;
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
            ev_if.op <= OP_FRAME;
            ev_if.event_time <= '0;
            ev_if.start_backwards <= 1'b0;
            ev_if.seek_position <= '0;
            ev_gap = 0;
            timeline_reset();
        end else begin
            if (ev_if.valid && ev_if.ready) begin
                e.op = t_op'(ev_if.op);
                e.t = ev_if.event_time;
                e.back = ev_if.start_backwards;
                e.pos = ev_if.seek_position;
                expected_results.push_back(predict_timeline(e));
            end
            if (!ev_if.valid || ev_if.ready) begin
                if (ev_gap > 0) begin
                    ev_gap = ev_gap - 1;
                    ev_if.valid <= 1'b0;
                end else if (pending_events.size() > 0 &&
                             !(pending_events[0].drain && expected_results.size() > 0)) begin
                    e = pending_events.pop_front();
                    ev_if.valid <= 1'b1;
                    ev_if.op <= e.op;
                    ev_if.event_time <= e.t;
                    ev_if.start_backwards <= e.back;
                    ev_if.seek_position <= e.pos;
                    n_sent++;
                    ev_gap = ((n_sent / 64) % 4 == 0) ? 0 : $urandom_range(0, 10);
                end else begin
                    ev_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer against the oldest prediction
    int res_stall;
    always @(posedge i_clk) begin
        result_t x, a;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_stall = 0;
        end else if (res_if.valid && res_if.ready) begin
            a.value_valid = res_if.value_valid;
            a.fraction = res_if.fraction;
            a.done_res = res_if.done_res;
            a.is_running = res_if.is_running;
            a.iteration = res_if.iteration;
            a.backwards = res_if.playing_backwards;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, a);
                n_fail++;
            end else begin
                x = expected_results.pop_front();
                if (x != a) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, x, a);
                    n_fail++;
                end
            end
            n_checked++;
            // hold off for a long stretch once, so the block backs up
            if (n_checked == 150) res_stall = 400;
            else res_stall = ((n_checked / 50) % 4 == 1) ? 0 : $urandom_range(0, 10);
            res_if.ready <= (res_stall == 0);
        end else if (res_stall > 0) begin
            res_stall = res_stall - 1;
            res_if.ready <= (res_stall == 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DURATION: c_dur = 64'(val);
            REG_DELAY:    c_dly = 64'(val);
            REG_REPEAT:   c_rep = 64'(val[30:0]);
            REG_FOREVER:  c_fwd = val[0];
            REG_REVERSE:  c_rev = val[0];
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [31:0] dur, logic [31:0] dly, logic [31:0] rep,
                                 bit fwd, bit rev);
        reg_write(REG_DURATION, dur);
        reg_write(REG_DELAY, dly);
        reg_write(REG_REPEAT, rep);
        reg_write(REG_FOREVER, {31'd0, fwd});
        reg_write(REG_REVERSE, {31'd0, rev});
    endtask

    task automatic queue_event(t_op op, logic [39:0] t, bit back, logic [31:0] pos, bit drain);
        event_t e;
        e.op = op;
        e.t = t;
        e.back = back;
        e.pos = pos;
        e.drain = drain;
        pending_events.push_back(e);
    endtask

    task automatic wait_idle();
        while (pending_events.size() > 0 || expected_results.size() > 0 || ev_if.valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Mostly well-formed play sessions with random timing, some noise
    task automatic queue_session(int n, int span);
        int r;
        t_op op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) now_ms = now_ms - 40'($urandom_range(0, span));
            else now_ms = now_ms + 40'($urandom_range(0, span));
            if (r < 50) op = OP_FRAME;
            else if (r < 60) op = OP_START;
            else if (r < 67) op = OP_PAUSE;
            else if (r < 74) op = OP_RESUME;
            else if (r < 80) op = OP_SEEK;
            else if (r < 84) op = OP_END;
            else if (r < 89) op = OP_CANCEL;
            else if (r < 94) op = OP_REVERSE;
            else op = t_op'($urandom_range(0, 7));
            if (r >= 94)
                queue_event(op, {8'($urandom), $urandom}, 1'($urandom_range(0, 1)), $urandom,
                            k == n / 2);
            else
                queue_event(op, now_ms, 1'($urandom_range(0, 1)),
                            (r < 77) ? 32'($urandom_range(0, 4 * span)) : $urandom, k == n / 2);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        c_dur = 300;
        c_dly = 0;
        c_rep = 0;
        c_fwd = 0;
        c_rev = 0;
        now_ms = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: plain run, pause/resume, seek, reverse, extremes of time
        queue_event(OP_PAUSE,   40'd0,    0, 0, 0);
        queue_event(OP_RESUME,  40'd0,    0, 0, 0);
        queue_event(OP_START,   40'd0,    0, 0, 0);
        queue_event(OP_FRAME,   40'd0,    0, 0, 0);
        queue_event(OP_FRAME,   40'd150,  0, 0, 0);
        queue_event(OP_FRAME,   40'd300,  0, 0, 0);
        queue_event(OP_START,   40'd1000, 1, 0, 0);
        queue_event(OP_FRAME,   40'd1000, 0, 0, 0);
        queue_event(OP_FRAME,   40'd1100, 0, 0, 0);
        queue_event(OP_PAUSE,   40'd1150, 0, 0, 0);
        queue_event(OP_FRAME,   40'd1200, 0, 0, 0);
        queue_event(OP_FRAME,   40'd1300, 0, 0, 0);
        queue_event(OP_RESUME,  40'd1350, 0, 0, 0);
        queue_event(OP_FRAME,   40'd1400, 0, 0, 0);
        queue_event(OP_SEEK,    40'd1450, 0, 32'd100, 0);
        queue_event(OP_END,     40'd1500, 0, 0, 0);
        queue_event(OP_CANCEL,  40'd1600, 0, 0, 0);
        queue_event(OP_REVERSE, 40'd2000, 0, 0, 0);
        queue_event(OP_FRAME,   40'd2000, 0, 0, 0);
        queue_event(OP_FRAME,   40'd2100, 0, 0, 0);
        queue_event(OP_REVERSE, 40'd2150, 0, 0, 0);
        queue_event(OP_FRAME,   40'd2200, 0, 0, 0);
        queue_event(OP_START,   {40{1'b1}}, 0, 0, 0);
        queue_event(OP_FRAME,   40'd0,    0, 0, 0);
        queue_event(OP_SEEK,    {40{1'b1}}, 0, 32'hFFFF_FFFF, 1);
        queue_event(OP_REVERSE, 40'd5,    1, 0, 0);
        wait_idle();

        queue_session(200, 120);
        wait_idle();
        set_registers(32'd1000, 32'd0, 32'd3, 1'b0, 1'b1);
        queue_session(200, 400);
        wait_idle();
        set_registers(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
        queue_session(150, 50);
        wait_idle();
        set_registers(32'd64, 32'd50, 32'd0, 1'b1, 1'b1);
        queue_session(200, 100);
        wait_idle();
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        now_ms = {8'($urandom), $urandom};
        queue_session(120, 32'h7FFF_FFFF);
        wait_idle();
        set_registers(32'd1, 32'd1, 32'h7FFF_FFFF, 1'b0, 1'b1);
        queue_session(150, 2000);
        wait_idle();
        set_registers($urandom_range(1, 500), $urandom_range(0, 300), $urandom_range(0, 5),
                      1'b0, 1'b1);
        queue_session(260, 200);
        wait_idle();

        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### animation_timeline_sequencer.f
+incdir+hw/rtl
hw/rtl/atl_pkg.sv
hw/rtl/atl_if.sv
hw/rtl/atl_cfg.sv
hw/rtl/atl_ctrl.sv
hw/rtl/atl_dpath.sv
hw/rtl/animation_timeline_sequencer.sv
sim/animation_timeline_sequencer_tb.sv
